@@ design/rdir_pkg.sv @@
package rdir_pkg;

    // Working format: signed fixed point with W_FRAC fraction bits.
    typedef logic signed [63:0] t_w;

    localparam int unsigned W_FRAC               = 30;
    localparam int unsigned VECTOR_FRAC_BITS_DEF = 14;
    localparam t_w          ONE_W                = t_w'(64'd1 << W_FRAC);
    localparam t_w          LIM_W                = t_w'((64'd1 << 61) - 64'd1);

    // Saturating add in the working format, limits are +-LIM_W.
    function automatic t_w sat_add(input t_w a, input t_w b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(LIM_W)) begin
            return LIM_W;
        end else if (s < -65'(LIM_W)) begin
            return -LIM_W;
        end
        return s[63:0];
    endfunction

endpackage

@@ design/rdir_pipe.sv @@
module rdir_pipe #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_q [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= i_d;
            for (int i = 1; i < DEPTH; i++) begin
                r_q[i] <= r_q[i-1];
            end
        end
    end

    assign o_q = r_q[DEPTH-1];

endmodule

@@ design/rdir_mulw.sv @@
module rdir_mulw (
    input  logic           i_clk,
    input  logic           i_en,
    input  rdir_pkg::t_w   i_a,
    input  rdir_pkg::t_w   i_b,
    output rdir_pkg::t_w   o_p
);
    import rdir_pkg::*;

    // Three stages: partial products, their sum, then rounding and sign.
    logic [60:0]  ma, mb;
    logic         r_neg1, r_neg2;
    logic [61:0]  r_ll;
    logic [60:0]  r_lh, r_hl;
    logic [59:0]  r_hh;
    logic [121:0] r_sum;
    logic [92:0]  mf;
    logic [60:0]  m;
    t_w           r_p;

    always_comb begin
        ma = i_a[63] ? 61'(-i_a) : i_a[60:0];
        mb = i_b[63] ? 61'(-i_b) : i_b[60:0];
        mf = 93'((r_sum + 122'(64'd1 << (W_FRAC - 1))) >> W_FRAC);
        m  = (|mf[92:61]) ? LIM_W[60:0] : mf[60:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg1 <= i_a[63] ^ i_b[63];
            r_ll   <= ma[30:0] * mb[30:0];
            r_lh   <= ma[30:0] * mb[60:31];
            r_hl   <= ma[60:31] * mb[30:0];
            r_hh   <= ma[60:31] * mb[60:31];
            r_neg2 <= r_neg1;
            r_sum  <= 122'(r_ll) + (122'(62'(r_lh) + 62'(r_hl)) << 31) + (122'(r_hh) << 62);
            r_p    <= r_neg2 ? -t_w'({3'b0, m}) : t_w'({3'b0, m});
        end
    end

    assign o_p = r_p;

endmodule

@@ design/refraction_direction_top.sv @@
// Refraction direction unit.
// Input stream (s_axis): one item per ray hit carrying the leaving and entering
// refractive indices (unsigned Q3.13) and the incident and normal vectors
// (signed, VECTOR_FRAC_BITS fraction bits). Output stream (m_axis): the
// refracted or mirrored direction, saturated to 16 bits per component, with
// the total reflection and clipped flags on tuser.
// Throughput is one item per cycle unless the output stalls. From acceptance
// to the output register an item passes the 47-stage index divider, the
// 46-stage square root, three fixed point multiplier levels of three stages
// each and five single register stages for the adds, the select and the output.
// Every item yields exactly one result, in order.
// When the receiver stalls a valid output, the whole pipeline holds and
// s_axis tready drops in the same cycle; nothing is lost or repeated.
// Reset clears the valid bits of all stages; data registers are not reset.
module refraction_direction_top #(
    parameter int unsigned VECTOR_FRAC_BITS = rdir_pkg::VECTOR_FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // leaving_index, entering_index, incident_x/y/z, normal_x/y/z (16 bits each)
    input  logic [127:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // out_x, out_y, out_z (16 bits each)
    output logic [47:0]  o_m_axis_tdata,
    // total_reflection, clipped
    output logic [1:0]   o_m_axis_tuser
);
    import rdir_pkg::*;

    localparam int unsigned DIV_N = 47;
    localparam int unsigned SQ_N  = 46;
    localparam int unsigned VLD_N = 106;
    localparam int unsigned VSH   = W_FRAC - VECTOR_FRAC_BITS;
    localparam int unsigned CL    = (2 * VECTOR_FRAC_BITS <= W_FRAC) ?
                                    W_FRAC - 2 * VECTOR_FRAC_BITS : 0;
    localparam int unsigned CR    = (2 * VECTOR_FRAC_BITS > W_FRAC) ?
                                    2 * VECTOR_FRAC_BITS - W_FRAC : 0;

    // Drop s fraction bits, round to nearest with ties away from zero.
    function automatic t_w rnd_shift(input t_w v, input int unsigned s);
        t_w mg;
        t_w rd;
        mg = v[63] ? -v : v;
        rd = (s == 0) ? t_w'(0) : (t_w'(1) <<< (s - 1));
        mg = (mg + rd) >>> s;
        return v[63] ? -mg : mg;
    endfunction

    logic adv;
    logic r_ovalid;
    logic [VLD_N-1:0] r_vld;

    assign adv             = !r_ovalid || i_m_axis_tready;
    assign o_s_axis_tready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_ovalid <= 1'b0;
        end else if (adv) begin
            r_vld    <= {r_vld[VLD_N-2:0], i_s_axis_tvalid};
            r_ovalid <= r_vld[VLD_N-1];
        end
    end

    // Index ratio, one quotient bit per stage.
    logic [15:0]      den0;
    logic [DIV_N-1:0] num0;
    logic [15:0]      r_dv_rem [DIV_N];
    logic [15:0]      r_dv_den [DIV_N];
    logic [DIV_N-1:0] r_dv_num [DIV_N];
    logic [DIV_N-1:0] r_dv_q   [DIV_N];

    assign den0 = (i_s_axis_tdata[31:16] == 16'd0) ? 16'd1 : i_s_axis_tdata[31:16];
    assign num0 = {1'b0, i_s_axis_tdata[15:0], 30'b0} + DIV_N'(den0[15:1]);

    for (genvar s = 0; s < DIV_N; s++) begin : g_div
        logic [15:0]      prem, pden;
        logic [DIV_N-1:0] pnum, pq;
        logic [16:0]      t, diff;
        logic             ge;
        if (s == 0) begin : g_first
            assign prem = '0;
            assign pden = den0;
            assign pnum = num0;
            assign pq   = '0;
        end else begin : g_next
            assign prem = r_dv_rem[s-1];
            assign pden = r_dv_den[s-1];
            assign pnum = r_dv_num[s-1];
            assign pq   = r_dv_q[s-1];
        end
        assign t    = {prem, pnum[DIV_N-1-s]};
        assign ge   = t >= {1'b0, pden};
        assign diff = t - {1'b0, pden};
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dv_rem[s] <= ge ? diff[15:0] : t[15:0];
                r_dv_den[s] <= pden;
                r_dv_num[s] <= pnum;
                r_dv_q[s]   <= pq | (DIV_N'(ge) << (DIV_N - 1 - s));
            end
        end
    end

    // Dot product and the raw vectors.
    logic signed [31:0] r_prod [3];
    logic [95:0]        r_vec;
    logic signed [33:0] dot;
    t_w                 r_c;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int j = 0; j < 3; j++) begin
                r_prod[j] <= $signed(i_s_axis_tdata[32+16*j +: 16]) *
                             $signed(i_s_axis_tdata[80+16*j +: 16]);
            end
            r_vec <= i_s_axis_tdata[127:32];
            r_c   <= rnd_shift(t_w'(dot), CR) <<< CL;
        end
    end

    assign dot = 34'(r_prod[0]) + 34'(r_prod[1]) + 34'(r_prod[2]);

    t_w c47, eta47, twoc47, cc50, ee50, ec50, sin54;
    t_w r_onem, r_ee51, r_k;
    logic r_tir55;

    rdir_pipe #(.WIDTH(64), .DEPTH(45)) u_pc (
        .i_clk(i_clk), .i_en(adv), .i_d(r_c), .o_q(c47)
    );

    assign eta47  = t_w'({17'b0, r_dv_q[DIV_N-1]});
    assign twoc47 = sat_add(c47, c47);

    rdir_mulw u_mcc (.i_clk(i_clk), .i_en(adv), .i_a(c47),   .i_b(c47),   .o_p(cc50));
    rdir_mulw u_mee (.i_clk(i_clk), .i_en(adv), .i_a(eta47), .i_b(eta47), .o_p(ee50));
    rdir_mulw u_mec (.i_clk(i_clk), .i_en(adv), .i_a(eta47), .i_b(c47),   .o_p(ec50));

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_onem <= sat_add(ONE_W, -cc50);
            r_ee51 <= ee50;
        end
    end

    rdir_mulw u_msin (.i_clk(i_clk), .i_en(adv), .i_a(r_ee51), .i_b(r_onem), .o_p(sin54));

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tir55 <= sin54 > ONE_W;
            r_k     <= ONE_W - sin54;
        end
    end

    // Square root of k * 2^30, one result bit per stage. Only used when k >= 0.
    logic [91:0]     r_sq_rem  [SQ_N];
    logic [SQ_N-1:0] r_sq_root [SQ_N];

    for (genvar s = 0; s < SQ_N; s++) begin : g_sqrt
        localparam int unsigned B = SQ_N - 1 - s;
        logic [91:0]     prem, trial;
        logic [SQ_N-1:0] proot;
        logic            ge;
        if (s == 0) begin : g_first
            assign prem  = {r_k[61:0], 30'b0};
            assign proot = '0;
        end else begin : g_next
            assign prem  = r_sq_rem[s-1];
            assign proot = r_sq_root[s-1];
        end
        assign trial = (92'(proot) << (B + 1)) | (92'd1 << (2 * B));
        assign ge    = prem >= trial;
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_sq_rem[s]  <= ge ? prem - trial : prem;
                r_sq_root[s] <= proot | (SQ_N'(ge) << B);
            end
        end
    end

    t_w   twoc101, ec101, eta102, r_sel;
    logic tir101, r_tir102, tir105, r_tir106;
    logic [95:0] vec102;
    logic [47:0] inc105;

    rdir_pipe #(.WIDTH(64), .DEPTH(54)) u_ptwoc (
        .i_clk(i_clk), .i_en(adv), .i_d(twoc47), .o_q(twoc101)
    );
    rdir_pipe #(.WIDTH(64), .DEPTH(51)) u_pec (
        .i_clk(i_clk), .i_en(adv), .i_d(ec50), .o_q(ec101)
    );
    rdir_pipe #(.WIDTH(1), .DEPTH(46)) u_ptir (
        .i_clk(i_clk), .i_en(adv), .i_d(r_tir55), .o_q(tir101)
    );
    rdir_pipe #(.WIDTH(64), .DEPTH(55)) u_peta (
        .i_clk(i_clk), .i_en(adv), .i_d(eta47), .o_q(eta102)
    );
    rdir_pipe #(.WIDTH(96), .DEPTH(101)) u_pvec (
        .i_clk(i_clk), .i_en(adv), .i_d(r_vec), .o_q(vec102)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sel    <= tir101 ? twoc101 :
                        sat_add(ec101, t_w'({18'b0, r_sq_root[SQ_N-1]}));
            r_tir102 <= tir101;
        end
    end

    rdir_pipe #(.WIDTH(1), .DEPTH(3)) u_ptir2 (
        .i_clk(i_clk), .i_en(adv), .i_d(r_tir102), .o_q(tir105)
    );
    rdir_pipe #(.WIDTH(48), .DEPTH(3)) u_pinc (
        .i_clk(i_clk), .i_en(adv), .i_d(vec102[47:0]), .o_q(inc105)
    );

    t_w   ei [3];
    t_w   mn [3];
    t_w   r_res [3];
    t_w   q [3];
    logic [2:0] hi, lo;
    logic [15:0] r_out [3];
    logic r_tir_o, r_clip_o;

    for (genvar j = 0; j < 3; j++) begin : g_lane
        t_w iw102, nw102, iw105;
        assign iw102 = t_w'($signed(vec102[16*j +: 16])) <<< VSH;
        assign nw102 = t_w'($signed(vec102[48+16*j +: 16])) <<< VSH;
        assign iw105 = t_w'($signed(inc105[16*j +: 16])) <<< VSH;

        rdir_mulw u_mei (.i_clk(i_clk), .i_en(adv), .i_a(eta102), .i_b(iw102), .o_p(ei[j]));
        rdir_mulw u_mmn (.i_clk(i_clk), .i_en(adv), .i_a(r_sel),  .i_b(nw102), .o_p(mn[j]));

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_res[j] <= sat_add(tir105 ? iw105 : ei[j], -mn[j]);
            end
        end

        assign q[j]  = rnd_shift(r_res[j], VSH);
        assign hi[j] = q[j] > t_w'(32767);
        assign lo[j] = q[j] < t_w'(-32768);

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_out[j] <= hi[j] ? 16'h7fff : (lo[j] ? 16'h8000 : q[j][15:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tir106 <= tir105;
            r_tir_o  <= r_tir106;
            r_clip_o <= |(hi | lo);
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {r_out[2], r_out[1], r_out[0]};
    assign o_m_axis_tuser  = {r_clip_o, r_tir_o};

`ifndef SYNTHESIS
    // A clipped item has at least one component at a rail.
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1]) |->
        (r_out[0] == 16'h7fff || r_out[0] == 16'h8000 ||
         r_out[1] == 16'h7fff || r_out[1] == 16'h8000 ||
         r_out[2] == 16'h7fff || r_out[2] == 16'h8000))
        else $error("clipped set without a saturated component");

    // A stalled pipeline keeps its valid bits.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!adv) |=> ($stable(r_vld) && o_m_axis_tvalid))
        else $error("pipeline moved during a stall");

    // Nothing leaves the block right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!o_m_axis_tvalid && r_vld == '0))
        else $error("valid bits survive reset");
`endif

endmodule

@@ tb/refraction_direction_top_tb.sv @@
module refraction_direction_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rdir_pkg::*;

    localparam int unsigned VFRAC = VECTOR_FRAC_BITS_DEF;

    typedef struct packed {
        logic [15:0]        leaving;
        logic [15:0]        entering;
        logic signed [15:0] ix, iy, iz;
        logic signed [15:0] nx, ny, nz;
    } t_hit;

    typedef struct packed {
        logic signed [15:0] ox, oy, oz;
        logic               tir;
        logic               clip;
    } t_dir;

    typedef struct {
        t_hit hit;
        logic known;
        t_dir dir;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [127:0] i_s_axis_tdata;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [47:0]  o_m_axis_tdata;
    logic [1:0]   o_m_axis_tuser;

    refraction_direction_top dut (.*);

    t_dir pending_dirs[$];
    int   n_errors = 0;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    bit   stim_done = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    function automatic t_w w_sat(logic signed [64:0] s);
        if (s > 65'(LIM_W)) begin
            return LIM_W;
        end else if (s < -65'(LIM_W)) begin
            return -LIM_W;
        end
        return s[63:0];
    endfunction

    function automatic t_w w_add(t_w a, t_w b);
        return w_sat(65'(a) + 65'(b));
    endfunction

    function automatic logic [63:0] w_mag(t_w v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // Product rounded to nearest, ties away from zero, then saturated.
    function automatic t_w w_mul(t_w a, t_w b);
        logic [127:0] p;
        logic         neg;
        neg = a[63] ^ b[63];
        p = {64'd0, w_mag(a)} * {64'd0, w_mag(b)};
        p = (p + (128'd1 << (W_FRAC - 1))) >> W_FRAC;
        if (p > 128'(LIM_W)) p = 128'(LIM_W);
        return neg ? -t_w'(p[63:0]) : t_w'(p[63:0]);
    endfunction

    function automatic t_w w_root(t_w k);
        logic [127:0] goal;
        logic [63:0]  r;
        logic [63:0]  cand;
        goal = {64'd0, k} << W_FRAC;
        r = '0;
        for (int b = 46; b >= 0; b--) begin
            cand = r | (64'd1 << b);
            if ({64'd0, cand} * {64'd0, cand} <= goal) r = cand;
        end
        return t_w'(r);
    endfunction

    function automatic t_dir refract(t_hit h);
        logic [63:0] lv, en;
        t_w          eta, c, one_m, sin2, nf, twoc, m;
        t_w          iw[3], nw[3], res[3];
        t_w          dot;
        t_dir        d;
        logic [15:0] q[3];
        logic        clip;
        iw[0] = t_w'(h.ix) <<< (W_FRAC - VFRAC);
        iw[1] = t_w'(h.iy) <<< (W_FRAC - VFRAC);
        iw[2] = t_w'(h.iz) <<< (W_FRAC - VFRAC);
        nw[0] = t_w'(h.nx) <<< (W_FRAC - VFRAC);
        nw[1] = t_w'(h.ny) <<< (W_FRAC - VFRAC);
        nw[2] = t_w'(h.nz) <<< (W_FRAC - VFRAC);
        dot = t_w'(h.ix) * t_w'(h.nx) + t_w'(h.iy) * t_w'(h.ny) + t_w'(h.iz) * t_w'(h.nz);
        lv = 64'(h.leaving);
        en = (h.entering == 0) ? 64'd1 : 64'(h.entering);
        eta = t_w'(((lv << W_FRAC) + (en >> 1)) / en);
        c = w_sat(65'(dot <<< (W_FRAC - 2 * VFRAC)));
        one_m = w_add(ONE_W, -w_mul(c, c));
        sin2 = w_mul(w_mul(eta, eta), one_m);
        d.tir = (sin2 > ONE_W);
        if (!d.tir) begin
            nf = w_add(w_mul(eta, c), w_root(ONE_W - sin2));
            for (int j = 0; j < 3; j++) res[j] = w_add(w_mul(eta, iw[j]), -w_mul(nf, nw[j]));
        end else begin
            twoc = w_add(c, c);
            for (int j = 0; j < 3; j++) res[j] = w_add(iw[j], -w_mul(twoc, nw[j]));
        end
        clip = 1'b0;
        for (int j = 0; j < 3; j++) begin
            m = t_w'((w_mag(res[j]) + (64'd1 << (W_FRAC - VFRAC - 1))) >> (W_FRAC - VFRAC));
            if (res[j][63]) m = -m;
            if (m > 32767) begin
                m = 32767;
                clip = 1'b1;
            end else if (m < -32768) begin
                m = -32768;
                clip = 1'b1;
            end
            q[j] = m[15:0];
        end
        d.ox = q[0];
        d.oy = q[1];
        d.oz = q[2];
        d.clip = clip;
        return d;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
        n_errors++;
    endtask

    function automatic t_hit to_hit(logic [15:0] lv, logic [15:0] en,
                                    int ix, int iy, int iz, int nx, int ny, int nz);
        t_hit h;
        h.leaving = lv;
        h.entering = en;
        h.ix = 16'(ix);
        h.iy = 16'(iy);
        h.iz = 16'(iz);
        h.nx = 16'(nx);
        h.ny = 16'(ny);
        h.nz = 16'(nz);
        return h;
    endfunction

    // Drives one item and records the expected direction once it is accepted.
    task automatic send_hit(t_hit h, logic known, t_dir dir);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {h.nz, h.ny, h.nx, h.iz, h.iy, h.ix, h.entering, h.leaving};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_dirs.push_back(known ? dir : refract(h));
    endtask

    function automatic logic [15:0] rand_index();
        case ($urandom_range(9))
            0: return 16'($urandom_range(65535));
            1: return 16'($urandom_range(8191));
            default: return 16'($urandom_range(16384, 8192));
        endcase
    endfunction

    function automatic int rand_comp();
        case ($urandom_range(5))
            0: return int'($urandom_range(65535)) - 32768;
            default: return int'($urandom_range(32768)) - 16384;
        endcase
    endfunction

    // Receiver side: stalls at the current rate, then checks each result.
    always @(posedge i_clk) begin
        t_dir want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_dirs.size() == 0) begin
                    $display("unexpected item on output at %0t", $realtime);
                    n_errors++;
                end else begin
                    want = pending_dirs.pop_front();
                    if (o_m_axis_tdata[15:0] !== want.ox)
                        report_mismatch("out_x", $signed(o_m_axis_tdata[15:0]), want.ox);
                    if (o_m_axis_tdata[31:16] !== want.oy)
                        report_mismatch("out_y", $signed(o_m_axis_tdata[31:16]), want.oy);
                    if (o_m_axis_tdata[47:32] !== want.oz)
                        report_mismatch("out_z", $signed(o_m_axis_tdata[47:32]), want.oz);
                    if (o_m_axis_tuser[0] !== want.tir)
                        report_mismatch("total_reflection", o_m_axis_tuser[0], want.tir);
                    if (o_m_axis_tuser[1] !== want.clip)
                        report_mismatch("clipped", o_m_axis_tuser[1], want.clip);
                end
            end
        end
    end

    initial begin
        t_row rows[$];
        t_row r;
        t_dir none;
        int   wait_cycles;
        none = '0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;

        // Straight-on hit with equal indices passes the ray unchanged.
        r.hit = to_hit(16'd8192, 16'd8192, 0, 0, -16384, 0, 0, 16384);
        r.known = 1'b1;
        r.dir = '{ox: 0, oy: 0, oz: -16384, tir: 1'b0, clip: 1'b0};
        rows.push_back(r);
        // Zero vectors: sin2 is exactly one, which still refracts.
        r.hit = to_hit(16'd8192, 16'd8192, 0, 0, 0, 0, 0, 0);
        r.dir = '{ox: 0, oy: 0, oz: 0, tir: 1'b0, clip: 1'b0};
        rows.push_back(r);
        // Grazing ray into a thinner medium reflects totally.
        r.hit = to_hit(16'd16384, 16'd8192, 16384, 0, 0, 0, 0, 16384);
        r.dir = '{ox: 16384, oy: 0, oz: 0, tir: 1'b1, clip: 1'b0};
        rows.push_back(r);
        r.known = 1'b0;
        r.dir = none;
        r.hit = to_hit(16'd0, 16'd0, 16384, 0, 0, 0, 16384, 0);   // zero indices
        rows.push_back(r);
        r.hit = to_hit(16'hFFFF, 16'd0, 11585, -11585, 0, 0, 16384, 0);  // huge eta
        rows.push_back(r);
        r.hit = to_hit(16'hFFFF, 16'hFFFF, 32767, 32767, 32767, 32767, 32767, 32767);
        rows.push_back(r);
        r.hit = to_hit(16'hFFFF, 16'd8192, -32768, -32768, -32768, -32768, -32768, -32768);
        rows.push_back(r);
        r.hit = to_hit(16'd8192, 16'hFFFF, -32768, 32767, -32768, 32767, -32768, 32767);
        rows.push_back(r);
        r.hit = to_hit(16'd12288, 16'd10923, 11585, -11585, 0, 0, 16384, 0);
        rows.push_back(r);
        r.hit = to_hit(16'd10923, 16'd12288, 9459, -9459, 9459, 0, 16384, 0);
        rows.push_back(r);
        r.hit = to_hit(16'd100, 16'd8192, 16384, 16384, 16384, 16384, 16384, 16384);
        rows.push_back(r);   // |c| above one
        r.hit = to_hit(16'd20000, 16'd8192, 16384, 0, 0, 0, 0, -16384);
        rows.push_back(r);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 25;
        rx_idle_pct = 75;
        foreach (rows[k]) send_hit(rows[k].hit, rows[k].known, rows[k].dir);

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 75 : 0;
            rx_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 25 : 0;
            for (int n = 0; n < 600; n++) begin
                send_hit(to_hit(rand_index(), rand_index(), rand_comp(), rand_comp(),
                                rand_comp(), rand_comp(), rand_comp(), rand_comp()),
                         1'b0, none);
            end
            if (phase == 0) begin
                // Let the pipeline drain completely before the next phase.
                i_s_axis_tvalid <= 1'b0;
                wait_cycles = 0;
                while (pending_dirs.size() != 0 && wait_cycles < 100000) begin
                    @(posedge i_clk);
                    wait_cycles++;
                end
            end
        end
        i_s_axis_tvalid <= 1'b0;

        wait_cycles = 0;
        while (pending_dirs.size() != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (200) @(posedge i_clk);
        if (n_errors == 0 && pending_dirs.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/rdir_pkg.sv
design/rdir_pipe.sv
design/rdir_mulw.sv
design/refraction_direction_top.sv
tb/refraction_direction_top_tb.sv
